// ----- sv/bfea_pkg.sv -----
package bfea_pkg;

    localparam int ENTRIES      = 16;
    localparam int ADDR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);
    localparam int BASE_W       = 32;
    localparam int SIZE_W       = 21;
    localparam int USED_W       = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int HEADER       = 4;
    localparam int HEAP_DEFAULT = 1024 * 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SIZE_W-1:0] request_bytes;
        logic [BASE_W-1:0] block_address;
        logic [SIZE_W-1:0] block_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [BASE_W-1:0] user_address;
        logic [USED_W-1:0] extents_used;
    } t_out_item;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } t_extent;

    localparam int EXT_W = $bits(t_extent);

endpackage

// ----- sv/best_fit_extent_allocator_unit.sv -----
// Best-fit extent allocator.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one command per
// transaction: init, allocate or free. Output channel (o_out_valid /
// i_out_ready / o_out_item) returns exactly one result per command.
// Configuration: i_cfg_we writes heap_base (index 0) or heap_bytes (index 1)
// from i_cfg_data; write only while no command is in flight.
// Sequence: init and the unused opcode go straight to the finish step after
// acceptance; allocate and free first scan the table, reading one entry at a
// time through the read port of the extent RAM, then make the last compare in
// the shared unit, leave the scan, and in the finish step do the update write
// and the result load.
// Flow: one command at a time; o_in_ready is high only while idle, so a new
// command is taken only after the last one has finished.
// A finished result sits in the output register; the next command is taken
// while it waits, and a later result holds in the update step until the
// receiver takes the earlier one.
// Reset clears the extent count, the sequencer and the output register and
// restores heap_base 0 and heap_bytes 1048576; the table contents are left
// undefined and are never read before they are written.
module best_fit_extent_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bfea_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfea_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bfea_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bfea_pkg::t_out_item                o_out_item
);
    import bfea_pkg::*;

    t_state            r_state, n_state;
    logic [BASE_W-1:0] r_heap_base;
    logic [SIZE_W-1:0] r_heap_bytes;
    logic [1:0]        r_op, n_op;
    logic [SIZE_W:0]   r_total, n_total;
    logic [BASE_W-1:0] r_start, n_start;
    logic [BASE_W-1:0] r_end, n_end;
    logic [SIZE_W-1:0] r_blen, n_blen;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_best_idx, n_best_idx;
    logic [BASE_W-1:0] r_best_base, n_best_base;
    logic [SIZE_W-1:0] r_best_size, n_best_size;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              accept;
    logic              out_free;
    logic              rd_en;
    t_extent           rd_ext;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_extent           wr_ext;
    logic              hit;
    logic [BASE_W-1:0] in_start;
    logic [SIZE_W:0]   merge_sum;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_en    = (r_state == ST_SCAN) && (r_idx < r_count);
    assign in_start = i_in_item.block_address - BASE_W'(HEADER);
    assign merge_sum = {1'b0, r_best_size} + {1'b0, r_blen};

    bfea_ram #(
        .WIDTH (EXT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_ext),
        .i_re    (rd_en),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_ext)
    );

    always_comb begin
        hit = 1'b0;
        if (r_pend) begin
            case (r_op)
                OP_ALLOC: hit = ({1'b0, rd_ext.size} >= r_total)
                                && (!r_found || (rd_ext.size < r_best_size));
                OP_FREE:  hit = !r_found && (rd_ext.base == r_end);
                default:  hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_item.opcode inside {OP_ALLOC, OP_FREE}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (!rd_en && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        n_op        = r_op;
        n_total     = r_total;
        n_start     = r_start;
        n_end       = r_end;
        n_blen      = r_blen;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[ADDR_W-1:0];
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_base = r_best_base;
        n_best_size = r_best_size;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_best_idx;
        wr_ext      = '{base: r_start, size: r_blen};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op    = i_in_item.opcode;
                    n_total = {1'b0, i_in_item.request_bytes} + (SIZE_W + 1)'(HEADER);
                    n_start = in_start;
                    n_end   = in_start + BASE_W'(i_in_item.block_bytes);
                    n_blen  = i_in_item.block_bytes;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            ST_SCAN: begin
                n_pend = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (hit) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_pend_idx;
                    n_best_base = rd_ext.base;
                    n_best_size = rd_ext.size;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.status       = STATUS_OK;
                    n_out_item.user_address = '0;
                    case (r_op)
                        OP_INIT: begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_ext  = '{base: r_heap_base, size: r_heap_bytes};
                            n_count = CNT_W'(1);
                        end
                        OP_ALLOC: begin
                            if (r_found) begin
                                wr_en  = 1'b1;
                                wr_ext = '{base: r_best_base + BASE_W'(r_total),
                                           size: r_best_size - r_total[SIZE_W-1:0]};
                                n_out_item.user_address = r_best_base + BASE_W'(HEADER);
                            end else begin
                                n_out_item.status = STATUS_NOFIT;
                            end
                        end
                        OP_FREE: begin
                            if (r_found) begin
                                wr_en  = 1'b1;
                                wr_ext = '{base: r_start,
                                           size: merge_sum[SIZE_W] ? '1
                                                 : merge_sum[SIZE_W-1:0]};
                            end else if (r_count < CNT_W'(ENTRIES)) begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[ADDR_W-1:0];
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_out_item.status = STATUS_FULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_item.extents_used = USED_W'(n_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_heap_base  <= '0;
            r_heap_bytes <= SIZE_W'(HEAP_DEFAULT);
            r_count      <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data[BASE_W-1:0];
                    CFG_HEAP_BYTES: r_heap_bytes <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_total     <= n_total;
        r_start     <= n_start;
        r_end       <= n_end;
        r_blen      <= n_blen;
        r_pend_idx  <= n_pend_idx;
        r_best_idx  <= n_best_idx;
        r_best_base <= n_best_base;
        r_best_size <= n_best_size;
        r_out_item  <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- sv/bfea_ram.sv -----
module bfea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bfea_checker.sv -----
module bfea_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [bfea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [bfea_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input bfea_pkg::t_in_item              i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input bfea_pkg::t_out_item             o_out_item
);
    import bfea_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.extents_used <= USED_W'(ENTRIES))
        else $error("extent count beyond table size");

    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != STATUS_OK) |-> o_out_item.user_address == '0)
        else $error("address returned with failure status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == STATUS_OK)
                     || (o_out_item.status == STATUS_NOFIT)
                     || (o_out_item.status == STATUS_FULL))
        else $error("unknown status code");

endmodule

bind best_fit_extent_allocator_unit bfea_checker u_bfea_checker (.*);

// ----- tb/tb_best_fit_extent_allocator_unit.sv -----
`timescale 1ns / 100ps

module tb_best_fit_extent_allocator_unit;
    import bfea_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS  = 400;
    localparam int PHASES       = 5;
    localparam int PRESSURE_AT  = 600;
    localparam int PRESSURE_LEN = 500;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [SIZE_W:0] SIZE_CAP = {1'b0, {SIZE_W{1'b1}}};

    typedef struct {
        t_in_item  cmd;
        bit        typed;
        t_out_item res;
    } t_plan_row;

    typedef struct {
        logic [BASE_W-1:0] addr;
        logic [SIZE_W-1:0] bytes;
    } t_held_block;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    best_fit_extent_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    logic [BASE_W-1:0] heap_base = '0;
    logic [SIZE_W-1:0] heap_bytes = SIZE_W'(HEAP_DEFAULT);
    logic [BASE_W-1:0] free_base [ENTRIES];
    logic [SIZE_W-1:0] free_size [ENTRIES];
    int                free_count = 0;

    t_out_item   pending_results [$];
    t_plan_row   plan_rows [$];
    t_held_block held_blocks [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  command_count = 0;
    int  grant_count = 0;
    int  nofit_count = 0;
    int  full_count = 0;
    int  merge_count = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_out_item allocator_step(input t_in_item cmd);
        t_out_item         res;
        logic [SIZE_W:0]   need;
        logic [SIZE_W:0]   sum;
        logic [BASE_W-1:0] start;
        logic [BASE_W-1:0] stop;
        int                best;
        bit                hit;
        res = '0;
        case (cmd.opcode)
            OP_INIT: begin
                free_base[0] = heap_base;
                free_size[0] = heap_bytes;
                free_count = 1;
            end
            OP_ALLOC: begin
                need = {1'b0, cmd.request_bytes} + (SIZE_W+1)'(HEADER);
                best = -1;
                for (int i = 0; i < free_count; i++) begin
                    if ({1'b0, free_size[i]} >= need &&
                        (best < 0 || free_size[i] < free_size[best])) begin
                        best = i;
                    end
                end
                if (best < 0) begin
                    res.status = STATUS_NOFIT;
                end else begin
                    res.user_address = free_base[best] + BASE_W'(HEADER);
                    free_base[best] = free_base[best] + BASE_W'(need);
                    free_size[best] = SIZE_W'({1'b0, free_size[best]} - need);
                end
            end
            OP_FREE: begin
                start = cmd.block_address - BASE_W'(HEADER);
                stop = start + BASE_W'(cmd.block_bytes);
                hit = 1'b0;
                for (int i = 0; i < free_count && !hit; i++) begin
                    if (free_base[i] == stop) begin
                        sum = {1'b0, free_size[i]} + {1'b0, cmd.block_bytes};
                        free_base[i] = start;
                        free_size[i] = (sum > SIZE_CAP) ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
                        hit = 1'b1;
                        merge_count++;
                    end
                end
                if (!hit) begin
                    if (free_count < ENTRIES) begin
                        free_base[free_count] = start;
                        free_size[free_count] = cmd.block_bytes;
                        free_count++;
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
            end
            default: ;
        endcase
        res.extents_used = USED_W'(free_count);
        return res;
    endfunction

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_command();
        t_in_item c;
        int       pick;
        int       slot;
        c = '0;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            c.opcode = OP_INIT;
        end else if (pick < 15) begin
            c.opcode = (pick < 5) ? OP_UNUSED : (pick < 10) ? OP_ALLOC : OP_FREE;
            c.request_bytes = SIZE_W'($urandom_range(0, HEAP_DEFAULT));
            c.block_address = $urandom;
            c.block_bytes = SIZE_W'($urandom_range(0, HEAP_DEFAULT));
        end else if (held_blocks.size() != 0 && $urandom_range(0, 99) < 45) begin
            slot = ($urandom_range(0, 1) != 0) ? held_blocks.size() - 1 :
                   $urandom_range(0, held_blocks.size() - 1);
            c.opcode = OP_FREE;
            c.block_address = held_blocks[slot].addr;
            c.block_bytes = held_blocks[slot].bytes;
            held_blocks.delete(slot);
        end else begin
            c.opcode = OP_ALLOC;
            pick = $urandom_range(0, 99);
            c.request_bytes = (pick < 85) ? SIZE_W'($urandom_range(0, 255)) :
                              (pick < 98) ? SIZE_W'($urandom_range(0, 8191)) :
                              SIZE_W'($urandom_range(0, HEAP_DEFAULT));
        end
        return c;
    endfunction

    task automatic plan(input logic [1:0] op, input logic [SIZE_W-1:0] req,
                        input logic [BASE_W-1:0] addr, input logic [SIZE_W-1:0] bytes,
                        input bit typed = 1'b0, input logic [1:0] st = STATUS_OK,
                        input logic [BASE_W-1:0] ua = '0, input int used = 0);
        t_plan_row row;
        row.cmd = '{opcode: op, request_bytes: req, block_address: addr, block_bytes: bytes};
        row.typed = typed;
        row.res = '{status: st, user_address: ua, extents_used: USED_W'(used)};
        plan_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAP_BASE) heap_base = val;
        else if (idx == CFG_HEAP_BYTES) heap_bytes = val[SIZE_W-1:0];
    endtask

    task automatic send_command(input t_in_item cmd, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item res;
        if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
        gap = gap_len(tx_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        res = allocator_step(cmd);
        pending_results.push_back(typed ? typed_res : res);
        command_count++;
        if (res.status == STATUS_NOFIT) nofit_count++;
        if (res.status == STATUS_FULL) full_count++;
        if (cmd.opcode == OP_INIT) begin
            held_blocks.delete();
        end else if (cmd.opcode == OP_ALLOC && res.status == STATUS_OK) begin
            grant_count++;
            held_blocks.push_back('{res.user_address, SIZE_W'(cmd.request_bytes + HEADER)});
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s at cycle %0d, got %h, expected %h", what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // results
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("transaction with nothing outstanding", 32'(o_out_item), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.status !== want.status)
                        report_mismatch("status", 32'(o_out_item.status), 32'(want.status));
                    if (o_out_item.user_address !== want.user_address)
                        report_mismatch("user_address", o_out_item.user_address,
                                        want.user_address);
                    if (o_out_item.extents_used !== want.extents_used)
                        report_mismatch("extents_used", 32'(o_out_item.extents_used),
                                        32'(want.extents_used));
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        int  hold;
        bit  pressed;
        hold = 0;
        pressed = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
                if (!pressed && results_seen >= PRESSURE_AT) begin
                    hold = PRESSURE_LEN;
                    pressed = 1'b1;
                end else begin
                    hold = gap_len(rx_quiet);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_out_item         none;
        logic [BASE_W-1:0] base_val;
        logic [SIZE_W-1:0] bytes_val;
        none = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_HEAP_BASE, '0);
        write_reg(CFG_HEAP_BYTES, CFG_DATA_W'(HEAP_DEFAULT));

        plan(OP_ALLOC, 0, 0, 0, 1'b1, STATUS_NOFIT, 0, 0);
        plan(OP_INIT, 0, 0, 0, 1'b1, STATUS_OK, 0, 1);
        plan(OP_UNUSED, SIZE_W'(HEAP_DEFAULT), '1, SIZE_W'(HEAP_DEFAULT), 1'b1, STATUS_OK, 0, 1);
        plan(OP_ALLOC, SIZE_W'(HEAP_DEFAULT), 0, 0, 1'b1, STATUS_NOFIT, 0, 1);
        plan(OP_ALLOC, SIZE_W'(HEAP_DEFAULT - HEADER), 0, 0, 1'b1, STATUS_OK, 4, 1);
        plan(OP_ALLOC, 0, 0, 0, 1'b1, STATUS_NOFIT, 0, 1);
        plan(OP_FREE, 0, 32'h0000_0004, SIZE_W'(HEAP_DEFAULT), 1'b1, STATUS_OK, 0, 1);
        plan(OP_FREE, 0, 32'h0000_0000, 4, 1'b1, STATUS_OK, 0, 1);
        plan(OP_FREE, 0, 32'hFFF0_0000, SIZE_W'(HEAP_DEFAULT), 1'b1, STATUS_OK, 0, 1);
        plan(OP_ALLOC, SIZE_W'(HEAP_DEFAULT), 0, 0);
        plan(OP_FREE, 0, 32'h0001_0004, 64);
        plan(OP_FREE, 0, 32'h0002_0004, 64);
        plan(OP_ALLOC, 60, 0, 0);
        plan(OP_FREE, 0, 32'h0005_0004, 0);
        plan(OP_FREE, 0, 32'hFFFF_FFFF, SIZE_W'(HEAP_DEFAULT));
        for (int k = 0; k < 11; k++) plan(OP_FREE, 0, 32'h8000_0004 + k * 32'h1000, 16);
        plan(OP_FREE, 0, 32'h9000_0004, 16, 1'b1, STATUS_FULL, 0, ENTRIES);
        plan(OP_FREE, 0, 32'h7FFF_FFF4, 16, 1'b1, STATUS_OK, 0, ENTRIES);
        plan(OP_ALLOC, 12, 0, 0);
        foreach (plan_rows[n]) send_command(plan_rows[n].cmd, plan_rows[n].typed, plan_rows[n].res);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin base_val = 32'h0000_1000; bytes_val = 4096; end
                1: begin base_val = 32'hFFFF_F000; bytes_val = 65536; end
                2: begin base_val = $urandom; bytes_val = 0; end
                3: begin base_val = '1; bytes_val = SIZE_W'(HEAP_DEFAULT); end
                default: begin
                    base_val = $urandom;
                    bytes_val = SIZE_W'($urandom_range(1, HEAP_DEFAULT));
                end
            endcase
            write_reg(CFG_HEAP_BASE, base_val);
            write_reg(CFG_HEAP_BYTES, CFG_DATA_W'(bytes_val));
            send_command('{opcode: OP_INIT, default: '0}, 1'b0, none);
            repeat (PHASE_ITEMS - 1) send_command(make_command(), 1'b0, none);
        end
        settle();

        $display("Ran %0d commands over %0d heap settings; %0d allocations granted,",
                 command_count, PHASES + 1, grant_count);
        $display("%0d refused for lack of space, %0d frees dropped on a full table, %0d merges.",
                 nofit_count, full_count, merge_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bfea_pkg.sv
sv/bfea_ram.sv
sv/best_fit_extent_allocator_unit.sv
sv/bfea_checker.sv
tb/tb_best_fit_extent_allocator_unit.sv
